@@ rtl/core/assert_macros.svh @@
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/ufp_pkg.sv @@
// shared types, codes and layout constants of the update frame parser
package ufp_pkg;

  // string length caps (exclusive upper bound)
  localparam int unsigned BOARD_ID_CAP     = 32;
  localparam int unsigned PARTITION_ID_CAP = 32;
  localparam int unsigned VERSION_CAP      = 32;

  // configuration register indexes
  localparam logic [2:0] REG_PROTOCOL_VERSION = 3'd0;
  localparam logic [2:0] REG_BEGIN_OPCODE     = 3'd1;
  localparam logic [2:0] REG_DATA_OPCODE      = 3'd2;
  localparam logic [2:0] REG_FINISH_OPCODE    = 3'd3;
  localparam logic [2:0] REG_ABORT_OPCODE     = 3'd4;
  localparam logic [2:0] REG_STATUS_OPCODE    = 3'd5;
  localparam logic [2:0] REG_MAX_FRAME_LEN    = 3'd6;
  localparam logic [2:0] REG_MAX_SIG_LEN      = 3'd7;

  // field tags
  localparam logic [3:0] TAG_NONE      = 4'd0;
  localparam logic [3:0] TAG_SESSION   = 4'd1;
  localparam logic [3:0] TAG_MANIFEST0 = 4'd2;
  localparam logic [3:0] TAG_HASH      = 4'd6;
  localparam logic [3:0] TAG_BOARD     = 4'd7;
  localparam logic [3:0] TAG_PARTITION = 4'd8;
  localparam logic [3:0] TAG_VERSION   = 4'd9;
  localparam logic [3:0] TAG_SIG_LEN   = 4'd10;
  localparam logic [3:0] TAG_SIG       = 4'd11;
  localparam logic [3:0] TAG_OFFSET    = 4'd12;
  localparam logic [3:0] TAG_DATA      = 4'd13;

  // command kinds
  localparam logic [2:0] KIND_BEGIN  = 3'd0;
  localparam logic [2:0] KIND_DATA   = 3'd1;
  localparam logic [2:0] KIND_FINISH = 3'd2;
  localparam logic [2:0] KIND_ABORT  = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  // frame layout positions
  localparam logic [8:0] POS_VERSION    = 9'd0;
  localparam logic [8:0] POS_OPCODE     = 9'd1;
  localparam logic [8:0] POS_SESSION_HI = 9'd9;
  localparam logic [8:0] POS_BODY       = 9'd10;
  localparam logic [8:0] POS_OFFSET_HI  = 9'd13;
  localparam logic [8:0] POS_DATA       = 9'd14;
  localparam logic [8:0] POS_HASH       = 9'd26;
  localparam logic [8:0] POS_BOARD_LEN  = 9'd58;
  localparam logic [8:0] POS_PART_LEN   = 9'd59;
  localparam logic [8:0] POS_VER_LEN    = 9'd60;
  localparam logic [8:0] POS_SIG_LEN    = 9'd61;
  localparam logic [8:0] POS_STRINGS    = 9'd62;

  localparam logic [8:0] LEN_MIN        = 9'd10;
  localparam logic [8:0] LEN_DATA_MIN   = 9'd14;
  localparam logic [7:0] SIG_LEN_MIN    = 8'd8;
  localparam logic [8:0] LEN_SATURATE   = 9'h1ff;

  // printable character window and excluded characters
  localparam logic [7:0] CHAR_LO        = 8'h21;
  localparam logic [7:0] CHAR_HI        = 8'h7e;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_EQUALS    = 8'h3d;

  typedef struct packed {
    logic [7:0] protocol_version;
    logic [7:0] begin_opcode;
    logic [7:0] data_opcode;
    logic [7:0] finish_opcode;
    logic [7:0] abort_opcode;
    logic [7:0] status_query_opcode;
    logic [8:0] max_frame_len;
    logic [7:0] max_signature_len;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    logic [3:0]  field_tag;
    logic [63:0] field_value;
    logic        frame_done;
    logic        frame_accepted;
    logic [2:0]  command_kind;
    logic [8:0]  frame_length;
  } res_t;

  function automatic logic char_ok(input logic [7:0] c);
    return (c >= CHAR_LO) && (c <= CHAR_HI) && (c != CHAR_BACKSLASH) && (c != CHAR_EQUALS);
  endfunction

  function automatic logic len_ok(input logic [7:0] n, input logic [8:0] cap);
    return (n != 8'd0) && ({1'b0, n} < cap);
  endfunction

endpackage

@@ rtl/core/ufp_cfg_regs.sv @@
// configuration register file of the update frame parser
module ufp_cfg_regs
  import ufp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  output cfg_t       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_version    <= 8'd1;
      cfg.begin_opcode        <= 8'd16;
      cfg.data_opcode         <= 8'd17;
      cfg.finish_opcode       <= 8'd18;
      cfg.abort_opcode        <= 8'd19;
      cfg.status_query_opcode <= 8'd20;
      cfg.max_frame_len       <= 9'd269;
      cfg.max_signature_len   <= 8'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROTOCOL_VERSION: cfg.protocol_version    <= cfg_data[7:0];
        REG_BEGIN_OPCODE:     cfg.begin_opcode        <= cfg_data[7:0];
        REG_DATA_OPCODE:      cfg.data_opcode         <= cfg_data[7:0];
        REG_FINISH_OPCODE:    cfg.finish_opcode       <= cfg_data[7:0];
        REG_ABORT_OPCODE:     cfg.abort_opcode        <= cfg_data[7:0];
        REG_STATUS_OPCODE:    cfg.status_query_opcode <= cfg_data[7:0];
        REG_MAX_FRAME_LEN:    cfg.max_frame_len       <= cfg_data;
        REG_MAX_SIG_LEN:      cfg.max_signature_len   <= cfg_data[7:0];
        default:              cfg.max_signature_len   <= cfg.max_signature_len;
      endcase
    end
  end

endmodule

@@ rtl/core/ufp_parse_core.sv @@
// per-frame parse state and the single-pass field and verdict logic
module ufp_parse_core
  import ufp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       fire,
  input  logic [7:0] in_byte,
  input  logic       end_of_frame,
  output res_t       res
);

  localparam logic [8:0] BOARD_CAP_W = 9'(BOARD_ID_CAP);
  localparam logic [8:0] PART_CAP_W  = 9'(PARTITION_ID_CAP);
  localparam logic [8:0] VER_CAP_W   = 9'(VERSION_CAP);

  logic [8:0]  byte_position, byte_position_next;
  logic [7:0]  opcode_seen, opcode_seen_next;
  logic        reject_flag, reject_flag_next;
  logic [63:0] scalar_accumulator, scalar_accumulator_next;
  logic [7:0]  board_length, board_length_next;
  logic [7:0]  partition_length, partition_length_next;
  logic [7:0]  version_length, version_length_next;
  logic [7:0]  signature_length, signature_length_next;

  function automatic logic [63:0] gather(input logic [63:0] acc, input logic [7:0] b,
                                         input logic [2:0] k);
    if (k == 3'd0) begin
      return {56'd0, b};
    end
    return acc | ({56'd0, b} << {k, 3'b000});
  endfunction

  logic [8:0]  p;
  logic [8:0]  cap;
  logic [9:0]  p_inc;
  logic [8:0]  len;
  logic [8:0]  pm2, pm10, q;
  logic [9:0]  end_board, end_part, end_ver, end_sig;
  logic [10:0] total;
  logic [3:0]  tag;
  logic [63:0] val;
  logic        rule, ok, accepted;
  logic [2:0]  kind;

  always_comb begin
    p     = byte_position;
    cap   = (cfg.max_frame_len == LEN_SATURATE) ? LEN_SATURATE : cfg.max_frame_len + 9'd1;
    p_inc = {1'b0, p} + 10'd1;
    len   = (p_inc > {1'b0, cap}) ? cap : p_inc[8:0];
    pm2   = p - 9'd2;
    pm10  = p - POS_BODY;
    q     = p - POS_STRINGS;

    // running ends of the string and signature sections
    end_board = {2'b00, board_length};
    end_part  = end_board + {2'b00, partition_length};
    end_ver   = end_part + {2'b00, version_length};
    end_sig   = end_ver + {2'b00, signature_length};

    opcode_seen_next        = opcode_seen;
    reject_flag_next        = reject_flag;
    scalar_accumulator_next = scalar_accumulator;
    board_length_next       = board_length;
    partition_length_next   = partition_length;
    version_length_next     = version_length;
    signature_length_next   = signature_length;
    tag = TAG_NONE;
    val = 64'd0;

    priority if (p >= cfg.max_frame_len) begin
      reject_flag_next = 1'b1;
    end else if (p == POS_VERSION) begin
      if (in_byte != cfg.protocol_version) reject_flag_next = 1'b1;
    end else if (p == POS_OPCODE) begin
      opcode_seen_next = in_byte;
      if (in_byte < cfg.begin_opcode || in_byte > cfg.status_query_opcode) begin
        reject_flag_next = 1'b1;
      end
    end else if (p < POS_BODY) begin
      scalar_accumulator_next = gather(scalar_accumulator, in_byte, pm2[2:0]);
      if (p == POS_SESSION_HI) begin
        tag = TAG_SESSION;
        val = scalar_accumulator_next;
        if (scalar_accumulator_next == 64'd0) reject_flag_next = 1'b1;
      end
    end else if (opcode_seen == cfg.begin_opcode) begin
      priority if (p < POS_HASH) begin
        // four little-endian manifest words
        scalar_accumulator_next = gather(scalar_accumulator, in_byte, {1'b0, pm10[1:0]});
        if (pm10[1:0] == 2'd3) begin
          tag = TAG_MANIFEST0 + {2'b00, pm10[3:2]};
          val = {32'd0, scalar_accumulator_next[31:0]};
        end
      end else if (p < POS_BOARD_LEN) begin
        tag = TAG_HASH;
        val = {56'd0, in_byte};
      end else if (p == POS_BOARD_LEN) begin
        board_length_next = in_byte;
      end else if (p == POS_PART_LEN) begin
        partition_length_next = in_byte;
      end else if (p == POS_VER_LEN) begin
        version_length_next = in_byte;
      end else if (p == POS_SIG_LEN) begin
        signature_length_next = in_byte;
        tag = TAG_SIG_LEN;
        val = {56'd0, in_byte};
      end else begin
        priority if ({1'b0, q} < end_board) tag = TAG_BOARD;
        else if ({1'b0, q} < end_part)      tag = TAG_PARTITION;
        else if ({1'b0, q} < end_ver)       tag = TAG_VERSION;
        else if ({1'b0, q} < end_sig)       tag = TAG_SIG;
        else                                tag = TAG_NONE;
        if ((tag == TAG_BOARD || tag == TAG_PARTITION || tag == TAG_VERSION) &&
            !char_ok(in_byte)) begin
          reject_flag_next = 1'b1;
        end
        if (tag != TAG_NONE) val = {56'd0, in_byte};
      end
    end else if (opcode_seen == cfg.data_opcode) begin
      if (p < POS_DATA) begin
        scalar_accumulator_next = gather(scalar_accumulator, in_byte, {1'b0, pm10[1:0]});
        if (p == POS_OFFSET_HI) begin
          tag = TAG_OFFSET;
          val = {32'd0, scalar_accumulator_next[31:0]};
        end
      end else begin
        tag = TAG_DATA;
        val = {56'd0, in_byte};
      end
    end else begin
      tag = TAG_NONE;
    end

    // verdict on the updated frame state
    total = 11'({2'b00, POS_STRINGS}) + {3'b000, board_length_next}
          + {3'b000, partition_length_next} + {3'b000, version_length_next}
          + {3'b000, signature_length_next};
    ok = !reject_flag_next && (len >= LEN_MIN) && (len <= cfg.max_frame_len);
    rule = 1'b0;
    kind = KIND_BEGIN;
    priority if (opcode_seen_next == cfg.begin_opcode) begin
      rule = (len >= POS_STRINGS) && (signature_length_next >= SIG_LEN_MIN) &&
             (signature_length_next <= cfg.max_signature_len) &&
             ({2'b00, len} == total) &&
             len_ok(board_length_next, BOARD_CAP_W) &&
             len_ok(partition_length_next, PART_CAP_W) &&
             len_ok(version_length_next, VER_CAP_W);
      kind = KIND_BEGIN;
    end else if (opcode_seen_next == cfg.data_opcode) begin
      rule = len > LEN_DATA_MIN;
      kind = KIND_DATA;
    end else if (opcode_seen_next == cfg.finish_opcode) begin
      rule = len == LEN_MIN;
      kind = KIND_FINISH;
    end else if (opcode_seen_next == cfg.abort_opcode) begin
      rule = len == LEN_MIN;
      kind = KIND_ABORT;
    end else if (opcode_seen_next == cfg.status_query_opcode) begin
      rule = len == LEN_MIN;
      kind = KIND_STATUS;
    end else begin
      rule = 1'b0;
    end
    accepted = end_of_frame && ok && rule;

    byte_position_next = len;
    if (end_of_frame) begin
      byte_position_next      = 9'd0;
      opcode_seen_next        = 8'd0;
      reject_flag_next        = 1'b0;
      scalar_accumulator_next = 64'd0;
      board_length_next       = 8'd0;
      partition_length_next   = 8'd0;
      version_length_next     = 8'd0;
      signature_length_next   = 8'd0;
    end

    res.emit           = (tag != TAG_NONE) || end_of_frame;
    res.field_tag      = tag;
    res.field_value    = val;
    res.frame_done     = end_of_frame;
    res.frame_accepted = accepted;
    res.command_kind   = accepted ? kind : KIND_BEGIN;
    res.frame_length   = len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= 9'd0;
      opcode_seen        <= 8'd0;
      reject_flag        <= 1'b0;
      scalar_accumulator <= 64'd0;
      board_length       <= 8'd0;
      partition_length   <= 8'd0;
      version_length     <= 8'd0;
      signature_length   <= 8'd0;
    end else if (fire) begin
      byte_position      <= byte_position_next;
      opcode_seen        <= opcode_seen_next;
      reject_flag        <= reject_flag_next;
      scalar_accumulator <= scalar_accumulator_next;
      board_length       <= board_length_next;
      partition_length   <= partition_length_next;
      version_length     <= version_length_next;
      signature_length   <= signature_length_next;
    end
  end

endmodule

@@ rtl/core/update_frame_parser.sv @@
// top level of the update frame parser: input register, parse core, result register
//
//  channel   | direction | word
//  s_axis    | in        | tdata: in_byte, tlast: end_of_frame
//  m_axis    | out       | tdata: field_value, frame_length; tuser: tag, verdict, kind
//  cfg       | in        | cfg_index selects the register, cfg_data the value
//
// one byte per cycle sustained unless the result side stalls; each word waits in the
// input register; a word that ends a field or a frame leaves via the result register
// the parse core updates its per-frame state once per byte, which sets the rate
// reset clears the frame state, the valid flags and loads the register defaults
// a stalled result holds the result register; the input register still takes a
// word, and further words wait only while both registers are full
module update_frame_parser
  import ufp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_frame
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [63:0] field_value, [72:64] frame_length, rest zero
  output logic [7:0]  m_axis_tuser,   // [3:0] field_tag, [4] frame_accepted, [7:5] command_kind
  output logic        m_axis_tlast,   // frame_done
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  cfg_t cfg;
  res_t res;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // result register
  logic        out_valid;
  logic [3:0]  out_tag;
  logic [63:0] out_value;
  logic        out_done;
  logic        out_accepted;
  logic [2:0]  out_kind;
  logic [8:0]  out_length;

  logic stage_free;
  logic fire;

  // the result register can take a new word when empty or being drained
  assign stage_free    = !out_valid || m_axis_tready;
  assign fire          = in_valid && stage_free;
  assign s_axis_tready = !in_valid || stage_free;

  ufp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ufp_parse_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fire         (fire),
    .in_byte      (in_byte),
    .end_of_frame (in_last),
    .res          (res)
  );

  // input register: filled on accept, emptied when the core consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // result register: only bytes that complete a field or close a frame land here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_free) begin
      out_valid <= fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit && stage_free) begin
      out_tag      <= res.field_tag;
      out_value    <= res.field_value;
      out_done     <= res.frame_done;
      out_accepted <= res.frame_accepted;
      out_kind     <= res.command_kind;
      out_length   <= res.frame_length;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_length, out_value};
  assign m_axis_tuser  = {out_kind, out_accepted, out_tag};
  assign m_axis_tlast  = out_done;

endmodule

@@ rtl/core/ufp_checker.sv @@
// port-level checks of the update frame parser, bound to the top level
`include "assert_macros.svh"

module ufp_checker
  import ufp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [7:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
               $stable(m_axis_tlast))

  // a verdict only comes with the word that closes a frame
  `ASSERT_IMPLIES(a_verdict_on_last, clk, rst, m_axis_tvalid && !m_axis_tlast,
                  m_axis_tuser[4] == 1'b0)

  // a command kind other than begin only on an accepted frame
  `ASSERT_IMPLIES(a_kind_needs_accept, clk, rst,
                  m_axis_tvalid && (m_axis_tuser[7:5] != KIND_BEGIN),
                  m_axis_tuser[4] && m_axis_tlast)

  // an untagged word closes the frame and carries a zero value
  `ASSERT_IMPLIES(a_untagged_word, clk, rst, m_axis_tvalid && (m_axis_tuser[3:0] == TAG_NONE),
                  m_axis_tlast && (m_axis_tdata[63:0] == 64'd0))

  // the byte count of a frame includes the current byte
  `ASSERT_IMPLIES(a_length_nonzero, clk, rst, m_axis_tvalid, m_axis_tdata[72:64] != 9'd0)

endmodule

bind update_frame_parser ufp_checker u_ufp_checker (.*);

@@ sim/update_frame_parser_chk.sv @@
// checker for the update frame parser: tracks the register file, predicts every result word and compares
module update_frame_parser_chk
  import ufp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  input  logic [7:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          pending,
  output int          failures,
  output int          frames_closed,
  output int          frames_passed,
  output int          words_checked
);

  typedef struct packed {
    logic [3:0]  tag;
    logic [63:0] value;
    logic        done;
    logic        accepted;
    logic [2:0]  kind;
    logic [8:0]  length;
  } field_word_t;

  field_word_t expected_words[$];
  cfg_t        regs;

  // per-frame parse state
  logic [8:0]  pos;
  logic [7:0]  opcode;
  logic        rejected;
  logic [63:0] acc;
  logic [7:0]  board_n;
  logic [7:0]  part_n;
  logic [7:0]  ver_n;
  logic [7:0]  sig_n;

  task automatic clear_frame;
    pos      = '0;
    opcode   = '0;
    rejected = 1'b0;
    acc      = '0;
    board_n  = '0;
    part_n   = '0;
    ver_n    = '0;
    sig_n    = '0;
  endtask

  // little-endian assembly of a multi-byte field
  task automatic collect(input logic [7:0] b, input int k);
    if (k == 0)
      acc = {56'd0, b};
    else
      acc = acc | ({56'd0, b} << (8 * (k & 7)));
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [8:0]  p;
    logic [8:0]  cap;
    logic [8:0]  len;
    logic [3:0]  tag;
    logic [63:0] val;
    logic        ok;
    logic        rule;
    logic [2:0]  kind;
    int          rel;
    int          q;
    int          total;
    field_word_t w;
    p   = pos;
    cap = (regs.max_frame_len < 9'd511) ? regs.max_frame_len + 9'd1 : 9'd511;
    len = ({1'b0, p} + 10'd1 > {1'b0, cap}) ? cap : p + 9'd1;
    pos = len;
    tag = TAG_NONE;
    val = '0;
    rel = int'(p) - int'(POS_BODY);

    if (p >= regs.max_frame_len) begin
      rejected = 1'b1;
    end else if (p == POS_VERSION) begin
      if (b != regs.protocol_version) rejected = 1'b1;
    end else if (p == POS_OPCODE) begin
      opcode = b;
      if (b < regs.begin_opcode || b > regs.status_query_opcode) rejected = 1'b1;
    end else if (p < POS_BODY) begin
      collect(b, int'(p) - 2);
      if (p == POS_SESSION_HI) begin
        tag = TAG_SESSION;
        val = acc;
        if (acc == '0) rejected = 1'b1;
      end
    end else if (opcode == regs.begin_opcode) begin
      // begin layout: manifest, hash, four lengths, strings, signature
      if (p < POS_HASH) begin
        collect(b, rel & 3);
        if ((rel & 3) == 3) begin
          tag = TAG_MANIFEST0 + 4'(rel / 4);
          val = {32'd0, acc[31:0]};
        end
      end else if (p < POS_BOARD_LEN) begin
        tag = TAG_HASH;
        val = {56'd0, b};
      end else if (p == POS_BOARD_LEN) begin
        board_n = b;
      end else if (p == POS_PART_LEN) begin
        part_n = b;
      end else if (p == POS_VER_LEN) begin
        ver_n = b;
      end else if (p == POS_SIG_LEN) begin
        sig_n = b;
        tag   = TAG_SIG_LEN;
        val   = {56'd0, b};
      end else begin
        q = int'(p) - int'(POS_STRINGS);
        if (q < board_n) begin
          tag = TAG_BOARD;
        end else if (q - board_n < part_n) begin
          tag = TAG_PARTITION;
        end else if (q - board_n - part_n < ver_n) begin
          tag = TAG_VERSION;
        end else if (q - board_n - part_n - ver_n < sig_n) begin
          tag = TAG_SIG;
        end
        // string characters must be printable, not backslash and not equals
        if ((tag == TAG_BOARD || tag == TAG_PARTITION || tag == TAG_VERSION) &&
            (b < CHAR_LO || b > CHAR_HI || b == CHAR_BACKSLASH || b == CHAR_EQUALS))
          rejected = 1'b1;
        if (tag != TAG_NONE) val = {56'd0, b};
      end
    end else if (opcode == regs.data_opcode) begin
      if (p < POS_DATA) begin
        collect(b, rel);
        if (p == POS_OFFSET_HI) begin
          tag = TAG_OFFSET;
          val = {32'd0, acc[31:0]};
        end
      end else begin
        tag = TAG_DATA;
        val = {56'd0, b};
      end
    end

    ok   = 1'b0;
    rule = 1'b0;
    kind = KIND_BEGIN;
    if (last) begin
      ok = !rejected && len >= LEN_MIN && len <= regs.max_frame_len;
      if (opcode == regs.begin_opcode) begin
        total = int'(POS_STRINGS) + board_n + part_n + ver_n + sig_n;
        rule  = len >= POS_STRINGS && sig_n >= SIG_LEN_MIN &&
                sig_n <= regs.max_signature_len && int'(len) == total &&
                board_n != 0 && board_n < BOARD_ID_CAP &&
                part_n != 0 && part_n < PARTITION_ID_CAP &&
                ver_n != 0 && ver_n < VERSION_CAP;
        kind  = KIND_BEGIN;
      end else if (opcode == regs.data_opcode) begin
        rule = len > LEN_DATA_MIN;
        kind = KIND_DATA;
      end else if (opcode == regs.finish_opcode) begin
        rule = len == LEN_MIN;
        kind = KIND_FINISH;
      end else if (opcode == regs.abort_opcode) begin
        rule = len == LEN_MIN;
        kind = KIND_ABORT;
      end else if (opcode == regs.status_query_opcode) begin
        rule = len == LEN_MIN;
        kind = KIND_STATUS;
      end
      if (!(ok && rule)) kind = KIND_BEGIN;
      clear_frame();
    end

    if (tag != TAG_NONE || last) begin
      w = '{tag, val, last, ok && rule, kind, len};
      expected_words.push_back(w);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    field_word_t want;
    if (rst) begin
      regs = '{8'd1, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 9'd269, 8'd64};
      clear_frame();
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROTOCOL_VERSION: regs.protocol_version    = cfg_data[7:0];
          REG_BEGIN_OPCODE:     regs.begin_opcode        = cfg_data[7:0];
          REG_DATA_OPCODE:      regs.data_opcode         = cfg_data[7:0];
          REG_FINISH_OPCODE:    regs.finish_opcode       = cfg_data[7:0];
          REG_ABORT_OPCODE:     regs.abort_opcode        = cfg_data[7:0];
          REG_STATUS_OPCODE:    regs.status_query_opcode = cfg_data[7:0];
          REG_MAX_FRAME_LEN:    regs.max_frame_len       = cfg_data;
          REG_MAX_SIG_LEN:      regs.max_signature_len   = cfg_data[7:0];
          default: ;
        endcase
      end
      // compare before predicting, so a stray word cannot match a fresh prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got tag %0d value %0h",
                   $time, m_axis_tuser[3:0], m_axis_tdata[63:0]);
          failures++;
        end else begin
          want = expected_words.pop_front();
          check_field("field_tag", want.tag, m_axis_tuser[3:0]);
          check_field("field_value", want.value, m_axis_tdata[63:0]);
          check_field("frame_done", want.done, m_axis_tlast);
          check_field("frame_accepted", want.accepted, m_axis_tuser[4]);
          check_field("command_kind", want.kind, m_axis_tuser[7:5]);
          check_field("frame_length", want.length, m_axis_tdata[72:64]);
          words_checked++;
          if (want.done) frames_closed++;
          if (want.done && want.accepted) frames_passed++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
    end
    pending <= expected_words.size();
  end

endmodule

@@ sim/update_frame_parser_tb.sv @@
// testbench top for the update frame parser: frame stimulus, flow control and verdict
module update_frame_parser_tb
  import ufp_pkg::*;
();

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [7:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_data;

  int pending;
  int failures;
  int frames_closed;
  int frames_passed;
  int words_checked;

  // ways of spoiling a frame on purpose
  typedef enum int {
    FLAW_NONE,
    FLAW_VERSION,
    FLAW_SESSION_ZERO,
    FLAW_BAD_CHAR,
    FLAW_SHORT,
    FLAW_LONG
  } flaw_e;

  cfg_t       cfg_now;        // register values the stimulus builds frames for
  logic [7:0] frame_bytes[$]; // frame being assembled
  int         bytes_sent;
  int         frames_sent;

  update_frame_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  update_frame_parser_chk checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .failures      (failures),
    .frames_closed (frames_closed),
    .frames_passed (frames_passed),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // gap length: mostly none, often short, now and then long
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // string lengths: mostly tiny, sometimes up to the largest length under the cap
  function automatic int pick_str_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(1, 31);
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [7:0] good_char();
    logic [7:0] c;
    do c = 8'($urandom_range(CHAR_LO, CHAR_HI));
    while (c == CHAR_BACKSLASH || c == CHAR_EQUALS);
    return c;
  endfunction

  function automatic logic [7:0] bad_char();
    case ($urandom_range(0, 5))
      0: return CHAR_BACKSLASH;
      1: return CHAR_EQUALS;
      2: return CHAR_LO - 8'd1;
      3: return CHAR_HI + 8'd1;
      4: return 8'($urandom_range(0, CHAR_LO - 1));
      default: return 8'($urandom_range(CHAR_HI + 1, 255));
    endcase
  endfunction

  // receiver: bursts of ready broken by stalls, now and then a long clean stretch
  initial begin
    int on_len;
    int off_len;
    forever begin
      on_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      off_len = pick_gap(1'b0);
      m_axis_tready <= 1'b1;
      repeat (on_len) @(posedge clk);
      if (off_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  // version, opcode and the eight session bytes
  task automatic start_frame(input logic [7:0] opcode, input flaw_e flaw);
    logic [63:0] session;
    frame_bytes.delete();
    frame_bytes.push_back(flaw == FLAW_VERSION ? cfg_now.protocol_version + 8'd1
                                               : cfg_now.protocol_version);
    frame_bytes.push_back(opcode);
    session = {$urandom, $urandom};
    if (session == '0) session[0] = 1'b1;
    if (flaw == FLAW_SESSION_ZERO) session = '0;
    for (int i = 0; i < 8; i++) frame_bytes.push_back(session[8*i +: 8]);
  endtask

  // any command: header then random body bytes, cut to the given length
  task automatic build_cmd(input logic [7:0] opcode, input int total, input flaw_e flaw);
    start_frame(opcode, flaw);
    while (frame_bytes.size() < total) frame_bytes.push_back(8'($urandom));
    while (frame_bytes.size() > total) void'(frame_bytes.pop_back());
  endtask

  // update begin: manifest, hash, lengths, three strings, signature
  task automatic build_begin(input int bl, input int pl, input int vl, input int sl,
                             input flaw_e flaw);
    start_frame(cfg_now.begin_opcode, flaw);
    repeat (48) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'(bl));
    frame_bytes.push_back(8'(pl));
    frame_bytes.push_back(8'(vl));
    frame_bytes.push_back(8'(sl));
    repeat (bl + pl + vl) frame_bytes.push_back(good_char());
    repeat (sl) frame_bytes.push_back(8'($urandom));
    if (flaw == FLAW_BAD_CHAR && bl + pl + vl > 0)
      frame_bytes[POS_STRINGS + $urandom_range(0, bl + pl + vl - 1)] = bad_char();
    if (flaw == FLAW_SHORT) void'(frame_bytes.pop_back());
    if (flaw == FLAW_LONG) frame_bytes.push_back(8'($urandom));
  endtask

  // push the assembled frame through the slave side, tlast on the final word
  task automatic send_frame;
    bit steady;
    int gap;
    steady = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      gap = pick_gap(steady);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= frame_bytes[i];
      s_axis_tlast  <= (i == frame_bytes.size() - 1);
      do @(posedge clk); while (!s_axis_tready);
    end
    bytes_sent += frame_bytes.size();
    frames_sent++;
  endtask

  // let every expected word arrive, then give the pipeline time to empty
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write the whole register file while the block is idle
  task automatic apply_config(input cfg_t c);
    write_reg(REG_PROTOCOL_VERSION, {1'b0, c.protocol_version});
    write_reg(REG_BEGIN_OPCODE, {1'b0, c.begin_opcode});
    write_reg(REG_DATA_OPCODE, {1'b0, c.data_opcode});
    write_reg(REG_FINISH_OPCODE, {1'b0, c.finish_opcode});
    write_reg(REG_ABORT_OPCODE, {1'b0, c.abort_opcode});
    write_reg(REG_STATUS_OPCODE, {1'b0, c.status_query_opcode});
    write_reg(REG_MAX_FRAME_LEN, c.max_frame_len);
    write_reg(REG_MAX_SIG_LEN, {1'b0, c.max_signature_len});
    cfg_valid <= 1'b0;
    cfg_now = c;
  endtask

  // random frames until the byte budget is spent; mostly well-formed commands
  task automatic random_frames(input int budget);
    int    start;
    int    r;
    int    bl;
    int    pl;
    int    vl;
    int    sl;
    int    sig_top;
    flaw_e flaw;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        bl      = pick_str_len();
        pl      = pick_str_len();
        vl      = pick_str_len();
        sig_top = (cfg_now.max_signature_len < 16) ? cfg_now.max_signature_len : 16;
        sl      = $urandom_range(SIG_LEN_MIN, sig_top);
        if ($urandom_range(0, 9) == 0) sl = cfg_now.max_signature_len;
        flaw    = FLAW_NONE;
        if ($urandom_range(0, 99) < 30) begin
          case ($urandom_range(0, 8))
            0: flaw = FLAW_VERSION;
            1: flaw = FLAW_SESSION_ZERO;
            2: flaw = FLAW_BAD_CHAR;
            3: flaw = FLAW_SHORT;
            4: flaw = FLAW_LONG;
            5: bl = 0;
            6: pl = PARTITION_ID_CAP;
            7: sl = SIG_LEN_MIN - 1;
            default: sl = (cfg_now.max_signature_len < 255) ? cfg_now.max_signature_len + 1
                                                            : SIG_LEN_MIN - 1;
          endcase
        end
        build_begin(bl, pl, vl, sl, flaw);
      end else if (r < 60) begin
        flaw = ($urandom_range(0, 19) == 0) ? FLAW_SESSION_ZERO : FLAW_NONE;
        build_cmd(cfg_now.data_opcode,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(15, 40),
                  flaw);
      end else if (r < 80) begin
        case ($urandom_range(0, 2))
          0: build_cmd(cfg_now.finish_opcode, 10, FLAW_NONE);
          1: build_cmd(cfg_now.abort_opcode, 10, FLAW_NONE);
          default: build_cmd(cfg_now.status_query_opcode, 10, FLAW_NONE);
        endcase
        // occasionally one byte short or one too many
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1) == 0) void'(frame_bytes.pop_back());
          else frame_bytes.push_back(8'($urandom));
        end
      end else if (r < 90) begin
        // opcode anywhere, often inside the accepted window, named code or not
        if ($urandom_range(0, 1) == 0 && cfg_now.begin_opcode <= cfg_now.status_query_opcode)
          build_cmd(8'($urandom_range(cfg_now.begin_opcode, cfg_now.status_query_opcode)),
                    $urandom_range(2, 20), FLAW_NONE);
        else
          build_cmd(8'($urandom), $urandom_range(2, 20), FLAW_NONE);
      end else begin
        // line noise
        frame_bytes.delete();
        repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
      end
      send_frame();
    end
  endtask

  initial begin
    cfg_t c;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    cfg_now       = '{8'd1, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 9'd269, 8'd64};
    bytes_sent    = 0;
    frames_sent   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames under the reset register values
    build_begin(1, 1, 1, SIG_LEN_MIN, FLAW_NONE);           // smallest good begin
    send_frame();
    build_begin(31, 31, 31, 64, FLAW_NONE);                 // every length at its top
    send_frame();
    build_begin(2, 2, 2, SIG_LEN_MIN, FLAW_BAD_CHAR);       // forbidden string character
    send_frame();
    build_begin(0, 1, 1, SIG_LEN_MIN, FLAW_NONE);           // empty board string
    send_frame();
    build_begin(1, PARTITION_ID_CAP, 1, SIG_LEN_MIN, FLAW_NONE); // string at its cap
    send_frame();
    build_begin(1, 1, 1, SIG_LEN_MIN - 1, FLAW_NONE);       // signature too short
    send_frame();
    build_begin(1, 1, 1, 65, FLAW_NONE);                    // signature too long
    send_frame();
    build_begin(1, 1, 1, SIG_LEN_MIN, FLAW_LONG);           // byte past the declared layout
    send_frame();
    build_begin(1, 1, 1, SIG_LEN_MIN, FLAW_SHORT);
    send_frame();
    build_cmd(cfg_now.data_opcode, 15, FLAW_NONE);          // shortest good data frame
    send_frame();
    build_cmd(cfg_now.data_opcode, 14, FLAW_NONE);          // data frame with no payload
    send_frame();
    build_cmd(cfg_now.data_opcode, 20, FLAW_NONE);          // all-ones session, offset and payload
    for (int i = 2; i < 20; i++) frame_bytes[i] = 8'hff;
    send_frame();
    build_cmd(cfg_now.finish_opcode, 10, FLAW_NONE);
    send_frame();
    build_cmd(cfg_now.abort_opcode, 10, FLAW_NONE);
    send_frame();
    build_cmd(cfg_now.status_query_opcode, 10, FLAW_NONE);
    send_frame();
    build_cmd(cfg_now.finish_opcode, 11, FLAW_NONE);        // finish one byte too long
    send_frame();
    build_cmd(cfg_now.status_query_opcode, 9, FLAW_NONE);   // below the minimum length
    send_frame();
    build_cmd(cfg_now.abort_opcode, 10, FLAW_VERSION);      // wrong version byte
    send_frame();
    build_cmd(cfg_now.begin_opcode - 8'd1, 10, FLAW_NONE);  // opcode below the window
    send_frame();
    build_cmd(cfg_now.status_query_opcode + 8'd1, 10, FLAW_NONE); // opcode above it
    send_frame();
    build_cmd(cfg_now.finish_opcode, 10, FLAW_SESSION_ZERO);
    send_frame();
    build_cmd(cfg_now.finish_opcode, 1, FLAW_NONE);         // lone byte with tlast
    send_frame();
    build_cmd(cfg_now.data_opcode, 275, FLAW_NONE);         // overlong, length saturates
    send_frame();

    random_frames(60);
    drain();

    // smallest frame and signature limits, opcode window wide with unnamed codes inside
    apply_config('{8'd255, 8'd0, 8'd1, 8'd2, 8'd3, 8'd255, 9'd10, 8'd8});
    random_frames(30);
    drain();

    // colliding opcodes, default frame limit, largest signature limit
    apply_config('{8'd0, 8'h40, 8'h40, 8'h42, 8'h42, 8'h45, 9'd269, 8'd255});
    random_frames(40);
    drain();

    // a few random register settings
    repeat (3) begin
      c.protocol_version    = 8'($urandom);
      c.begin_opcode        = 8'($urandom_range(0, 200));
      c.status_query_opcode = c.begin_opcode + 8'($urandom_range(4, 55));
      c.data_opcode         = 8'($urandom_range(c.begin_opcode, c.status_query_opcode));
      c.finish_opcode       = 8'($urandom_range(c.begin_opcode, c.status_query_opcode));
      c.abort_opcode        = 8'($urandom_range(c.begin_opcode, c.status_query_opcode));
      c.max_frame_len       = 9'($urandom_range(10, 269));
      c.max_signature_len   = 8'($urandom_range(8, 255));
      apply_config(c);
      random_frames(15);
      drain();
    end

    $display("run covered %0d bytes in %0d frames over six register settings",
             bytes_sent, frames_sent);
    $display("checked %0d result words, %0d frames closed, %0d of them accepted",
             words_checked, frames_closed, frames_passed);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ufp_pkg.sv
rtl/core/ufp_cfg_regs.sv
rtl/core/ufp_parse_core.sv
rtl/core/update_frame_parser.sv
rtl/core/ufp_checker.sv
sim/update_frame_parser_chk.sv
sim/update_frame_parser_tb.sv
